[rtl/core/sorted_merge_dedup_color_top_macros.svh]
`ifndef SORTED_MERGE_DEDUP_COLOR_TOP_MACROS_SVH
`define SORTED_MERGE_DEDUP_COLOR_TOP_MACROS_SVH

// Clocked check, masked while reset is held.
`define SMDC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check, also active during reset.
`define SMDC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/core/smdc_pkg.sv]
`default_nettype none

package smdc_pkg;

  localparam int unsigned WORD_W = 64;
  localparam int unsigned QDEPTH = 4;

  localparam logic [WORD_W-1:0] COLOR_A_RST = 64'h0000_0000_0000_0001;
  localparam logic [WORD_W-1:0] COLOR_B_RST = 64'h0000_0000_0000_0002;

  typedef enum logic [1:0] {
    CMD_PUSH_A = 2'd0,
    CMD_PUSH_B = 2'd1,
    CMD_END_A  = 2'd2,
    CMD_END_B  = 2'd3
  } smdc_cmd_t;

  typedef enum logic {
    REG_COLOR_A = 1'b0,
    REG_COLOR_B = 1'b1
  } smdc_reg_t;

  typedef struct packed {
    logic              has_pair;
    logic [WORD_W-1:0] value;
    logic [WORD_W-1:0] color;
    logic [1:0]        wants;
    logic              push_error;
    logic              last;
    logic              stream_done;
  } smdc_res_t;

  // results of one request: res0 always used, res1 only when two is set
  typedef struct packed {
    smdc_res_t res0;
    smdc_res_t res1;
    logic      two;
  } smdc_step_t;

endpackage

`default_nettype wire

[rtl/core/smdc_core.sv]
`default_nettype none

module smdc_core
  import smdc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic              cfg_addr,
  input  wire logic [WORD_W-1:0] cfg_wdata,
  input  wire logic              step_en,
  input  wire logic [1:0]        cmd,
  input  wire logic [WORD_W-1:0] word,
  output smdc_step_t             step_o
);

`include "sorted_merge_dedup_color_top_macros.svh"

  logic [WORD_W-1:0] color_a_r, color_b_r;
  logic [WORD_W-1:0] head_a_r, head_b_r;
  logic              head_a_valid_r, head_b_valid_r;
  logic              ended_a_r, ended_b_r;
  logic [WORD_W-1:0] pend_value_r, pend_color_r;
  logic              pend_valid_r;

  logic              perr;
  logic [WORD_W-1:0] ha, hb;
  logic              ha_v, hb_v, ea, eb;
  logic              a_lt_b, take_a, take_b, take, eq_a, eq_b, eq;
  logic [WORD_W-1:0] tv, tc;
  logic              emit1, flush, drained;
  logic              ha_v2, hb_v2;
  logic              pv1, pv2;
  logic [WORD_W-1:0] pval1, pcol1;
  logic [1:0]        wants;

  always_comb begin
    perr = 1'b0;
    ha   = head_a_r;
    hb   = head_b_r;
    ha_v = head_a_valid_r;
    hb_v = head_b_valid_r;
    ea   = ended_a_r;
    eb   = ended_b_r;
    case (smdc_cmd_t'(cmd))
      CMD_PUSH_A: begin
        if (head_a_valid_r || ended_a_r) begin
          perr = 1'b1;
        end else begin
          ha   = word;
          ha_v = 1'b1;
        end
      end
      CMD_PUSH_B: begin
        if (head_b_valid_r || ended_b_r) begin
          perr = 1'b1;
        end else begin
          hb   = word;
          hb_v = 1'b1;
        end
      end
      CMD_END_A: ea = 1'b1;
      CMD_END_B: eb = 1'b1;
      default:   perr = 1'b0;
    endcase

    // B wins a tie
    a_lt_b = ha < hb;
    take_a = ha_v && (hb_v ? a_lt_b : eb);
    take_b = hb_v && (ha_v ? !a_lt_b : ea);
    take   = take_a || take_b;
    eq_a   = pend_valid_r && (pend_value_r == ha);
    eq_b   = pend_valid_r && (pend_value_r == hb);
    tv     = take_a ? ha : hb;
    tc     = take_a ? color_a_r : color_b_r;
    eq     = take_a ? eq_a : eq_b;

    emit1 = take && pend_valid_r && !eq;
    pv1   = pend_valid_r || take;
    pval1 = (take && !eq) ? tv : pend_value_r;
    pcol1 = take ? (eq ? (pend_color_r | tc) : tc) : pend_color_r;

    ha_v2   = ha_v && !take_a;
    hb_v2   = hb_v && !take_b;
    flush   = ea && eb && !ha_v2 && !hb_v2 && pv1;
    pv2     = pv1 && !flush;
    drained = ea && eb && !ha_v2 && !hb_v2 && !pv2;
    wants   = {!hb_v2 && !eb, !ha_v2 && !ea};

    step_o.two = emit1 && flush;

    step_o.res0.has_pair    = emit1 || flush;
    step_o.res0.value       = emit1 ? pend_value_r : (flush ? pval1 : '0);
    step_o.res0.color       = emit1 ? pend_color_r : (flush ? pcol1 : '0);
    step_o.res0.wants       = wants;
    step_o.res0.push_error  = perr;
    step_o.res0.last        = !(emit1 && flush);
    step_o.res0.stream_done = !(emit1 && flush) && drained;

    step_o.res1.has_pair    = 1'b1;
    step_o.res1.value       = pval1;
    step_o.res1.color       = pcol1;
    step_o.res1.wants       = wants;
    step_o.res1.push_error  = perr;
    step_o.res1.last        = 1'b1;
    step_o.res1.stream_done = drained;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      color_a_r      <= COLOR_A_RST;
      color_b_r      <= COLOR_B_RST;
      head_a_valid_r <= 1'b0;
      head_b_valid_r <= 1'b0;
      ended_a_r      <= 1'b0;
      ended_b_r      <= 1'b0;
      pend_valid_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (smdc_reg_t'(cfg_addr))
          REG_COLOR_A: color_a_r <= cfg_wdata;
          REG_COLOR_B: color_b_r <= cfg_wdata;
          default:     color_a_r <= color_a_r;
        endcase
      end
      if (step_en) begin
        head_a_valid_r <= ha_v2;
        head_b_valid_r <= hb_v2;
        ended_a_r      <= ea;
        ended_b_r      <= eb;
        pend_valid_r   <= pv2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      head_a_r     <= ha;
      head_b_r     <= hb;
      pend_value_r <= pval1;
      pend_color_r <= pcol1;
    end
  end

  `SMDC_ASSERT(a_one_head, !(head_a_valid_r && head_b_valid_r), "both heads held")
  `SMDC_ASSERT(a_end_a_sticky, ended_a_r |=> ended_a_r, "end of A lost")
  `SMDC_ASSERT(a_end_b_sticky, ended_b_r |=> ended_b_r, "end of B lost")
  `SMDC_ASSERT(a_flushed,
    (ended_a_r && ended_b_r && !head_a_valid_r && !head_b_valid_r) |-> !pend_valid_r,
    "pending pair not flushed")

endmodule

`default_nettype wire

[rtl/core/smdc_outq.sv]
`default_nettype none

module smdc_outq
  import smdc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       push_en,
  input  wire smdc_step_t step_i,
  output logic            room_o,
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output smdc_res_t       head_o
);

`include "sorted_merge_dedup_color_top_macros.svh"

  localparam int unsigned PTR_W = $clog2(QDEPTH);
  localparam int unsigned CNT_W = $clog2(QDEPTH + 1);

  smdc_res_t          q_r [QDEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [PTR_W-1:0]   wr_ptr_nxt, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               pop;
  logic [CNT_W-1:0]   npush;

  assign pop        = out_tvalid && out_tready;
  assign out_tvalid = count_r != '0;
  assign head_o     = q_r[rd_ptr_r];
  assign room_o     = count_r <= CNT_W'(QDEPTH - 2);

  always_comb begin
    npush      = push_en ? (step_i.two ? CNT_W'(2) : CNT_W'(1)) : '0;
    count_nxt  = count_r + npush - CNT_W'(pop);
    wr_ptr_nxt = wr_ptr_r + npush[PTR_W-1:0];
    rd_ptr_nxt = rd_ptr_r + PTR_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
    end else begin
      count_r  <= count_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_en) begin
      q_r[wr_ptr_r] <= step_i.res0;
      if (step_i.two) begin
        q_r[wr_ptr_r + PTR_W'(1)] <= step_i.res1;
      end
    end
  end

  `SMDC_ASSERT(a_cnt_range, count_r <= CNT_W'(QDEPTH), "queue count out of range")
  `SMDC_ASSERT(a_no_ovf, push_en |-> room_o, "push without room")
  `SMDC_ASSERT(a_pop_only, (pop && !push_en) |=> count_r == $past(count_r) - CNT_W'(1),
    "count lost on pop")

endmodule

`default_nettype wire

[rtl/core/sorted_merge_dedup_color_top.sv]
// Results: a request's results enter the result queue on acceptance and leave on out_ in order.
// Throughput: one request per cycle while each yields a single result and out_tready
//   stays high; a request that emits a pair and flushes yields two, and out_ then drains one per cycle.
// The four-entry result queue sets the rate; in_tready drops with under two free.
// Reset: rst_n synchronous, active low; clears heads, end flags, pending pair and
//   queue, and loads the colour registers with A = 1 and B = 2.
`default_nettype none

module sorted_merge_dedup_color_top
  import smdc_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  // configuration: index 0 colour A, index 1 colour B
  input  wire logic         cfg_we,
  input  wire logic         cfg_addr,
  input  wire logic [63:0]  cfg_wdata,
  // request channel
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [63:0]  in_tdata,   // [63:0] word
  input  wire logic [1:0]   in_tuser,   // [1:0] cmd
  // result channel
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [135:0]      out_tdata,  // [63:0] merged_value, [127:64] color_mask,
                                        // [129:128] wants, [130] push_error,
                                        // [131] stream_done, [135:132] zero
  output logic [0:0]        out_tuser,  // [0] has_pair
  output logic              out_tlast   // step_done: last result of the request
);

  smdc_step_t step;
  smdc_res_t  head;
  logic       in_fire;
  logic       room;

  // request taken only when the queue can absorb two results
  assign in_tready = room;
  assign in_fire   = in_tvalid && in_tready;

  // merge state and per-request step logic; state moves on acceptance
  smdc_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .step_en   (in_fire),
    .cmd       (in_tuser),
    .word      (in_tdata),
    .step_o    (step)
  );

  // result registers parting the two sides
  smdc_outq u_outq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_en    (in_fire),
    .step_i     (step),
    .room_o     (room),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .head_o     (head)
  );

  assign out_tdata = {4'b0000, head.stream_done, head.push_error, head.wants,
                      head.color, head.value};
  assign out_tuser = head.has_pair;
  assign out_tlast = head.last;

endmodule

`default_nettype wire

[dv/testbench.sv]
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import smdc_pkg::*;

  // Cycles without any handshake before the run is declared hung. The longest
  // legitimate quiet stretch is the receiver hold-off.
  localparam int unsigned HANG_LIMIT  = 4000;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned PHASE_REQS  = 230;

  // ---------------------------------------------------------------------------
  // Scoreboard: mirrors the merge state and keeps the results still to come.
  // ---------------------------------------------------------------------------
  class merge_scoreboard;
    logic [63:0] colour_a = COLOR_A_RST;
    logic [63:0] colour_b = COLOR_B_RST;
    logic [63:0] a_word   = '0;
    logic [63:0] b_word   = '0;
    bit          a_full;
    bit          b_full;
    bit          a_closed;
    bit          b_closed;
    logic [63:0] held_value  = '0;
    logic [63:0] held_colour = '0;
    bit          held_valid;
    smdc_res_t   due_results[$];
    int          mismatches;
    int          results_seen;

    function void set_colour(smdc_reg_t idx, logic [63:0] val);
      if (idx == REG_COLOR_A) colour_a = val;
      else colour_b = val;
    endfunction

    function logic [1:0] wanted_streams();
      return {!b_full && !b_closed, !a_full && !a_closed};
    endfunction

    function smdc_res_t pair_result(logic [63:0] val, logic [63:0] col);
      smdc_res_t r;
      r          = '0;
      r.has_pair = 1'b1;
      r.value    = val;
      r.color    = col;
      return r;
    endfunction

    // One accepted request: update the mirror, queue the one or two results.
    function void note_request(smdc_cmd_t cmd, logic [63:0] word);
      smdc_res_t   step_res[$];
      smdc_res_t   r;
      bit          dropped;
      bit          took;
      logic [63:0] took_value;
      logic [63:0] took_colour;
      logic [1:0]  want;
      bit          drained;
      dropped     = 1'b0;
      took        = 1'b0;
      took_value  = '0;
      took_colour = '0;
      case (cmd)
        CMD_PUSH_A: begin
          if (a_full || a_closed) dropped = 1'b1;
          else begin
            a_word = word;
            a_full = 1'b1;
          end
        end
        CMD_PUSH_B: begin
          if (b_full || b_closed) dropped = 1'b1;
          else begin
            b_word = word;
            b_full = 1'b1;
          end
        end
        CMD_END_A: a_closed = 1'b1;
        default:   b_closed = 1'b1;
      endcase

      // at most one head word consumed; B wins a tie
      if (a_full && b_full) begin
        took = 1'b1;
        if (a_word < b_word) begin
          a_full      = 1'b0;
          took_value  = a_word;
          took_colour = colour_a;
        end else begin
          b_full      = 1'b0;
          took_value  = b_word;
          took_colour = colour_b;
        end
      end else if (a_full && b_closed) begin
        took        = 1'b1;
        a_full      = 1'b0;
        took_value  = a_word;
        took_colour = colour_a;
      end else if (b_full && a_closed) begin
        took        = 1'b1;
        b_full      = 1'b0;
        took_value  = b_word;
        took_colour = colour_b;
      end

      if (took) begin
        if (held_valid && held_value == took_value) held_colour |= took_colour;
        else begin
          if (held_valid) step_res.push_back(pair_result(held_value, held_colour));
          held_value  = took_value;
          held_colour = took_colour;
          held_valid  = 1'b1;
        end
      end

      // both sides finished and empty: flush the held pair now
      if (a_closed && b_closed && !a_full && !b_full && held_valid) begin
        step_res.push_back(pair_result(held_value, held_colour));
        held_valid = 1'b0;
      end

      if (step_res.size() == 0) step_res.push_back('0);

      want    = wanted_streams();
      drained = a_closed && b_closed && !a_full && !b_full && !held_valid;
      foreach (step_res[i]) begin
        r             = step_res[i];
        r.wants       = want;
        r.push_error  = dropped;
        r.last        = (i == step_res.size() - 1);
        r.stream_done = (i == step_res.size() - 1) && drained;
        due_results.push_back(r);
      end
    endfunction

    function void compare(string field, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d: %s expected %h, got %h", results_seen, field, want, got);
      end
    endfunction

    function void check_result(logic [135:0] data, logic has_pair, logic step_end);
      smdc_res_t due;
      results_seen++;
      if (due_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d: nothing due, got value %h colour %h",
                   results_seen, data[63:0], data[127:64]);
      end else begin
        due = due_results.pop_front();
        compare("has_pair",     due.has_pair,    has_pair);
        compare("merged_value", due.value,       data[63:0]);
        compare("color_mask",   due.color,       data[127:64]);
        compare("wants",        due.wants,       data[129:128]);
        compare("push_error",   due.push_error,  data[130]);
        compare("stream_done",  due.stream_done, data[131]);
        compare("padding",      64'd0,           data[135:132]);
        compare("step_done",    due.last,        step_end);
      end
    endfunction
  endclass

  // ---------------------------------------------------------------------------
  // DUT hookup
  // ---------------------------------------------------------------------------
  logic         clk;
  logic         rst_n;
  logic         cfg_we;
  logic         cfg_addr;
  logic [63:0]  cfg_wdata;
  logic         in_tvalid;
  logic         in_tready;
  logic [63:0]  in_tdata;   // [63:0] word
  logic [1:0]   in_tuser;   // [1:0] cmd
  logic         out_tvalid;
  logic         out_tready;
  logic [135:0] out_tdata;  // [63:0] value, [127:64] colour, [129:128] wants,
                            // [130] push_error, [131] stream_done, [135:132] zero
  logic [0:0]   out_tuser;  // [0] has_pair
  logic         out_tlast;  // last result of the request

  merge_scoreboard merge_sb = new();

  // sender shaping
  int          burst_left;
  int          gap_max;
  // last sorted word handed to each stream by the generator
  logic [63:0] last_a;
  logic [63:0] last_b;
  // main flow asks the receiver for one long hold-off
  bit          hold_off_req;
  int          idle_cycles;

  sorted_merge_dedup_color_top i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Drivers. Everything is driven with NBAs straight after a rising edge and
  // sampled in the active region of the next one, so values seen are the
  // pre-edge ones whatever the process order.
  // ---------------------------------------------------------------------------

  // Offer one request and hold it until it is taken. Bursts of random length
  // are separated by random gaps bounded by gap_max. tvalid is left high
  // on return so back-to-back requests never toggle it within one step.
  task automatic send_request(smdc_cmd_t cmd, logic [63:0] word);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, gap_max);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= word;
    do @(posedge clk); while (!in_tready);
    merge_sb.note_request(cmd, word);
  endtask

  // Stop offering and let every queued result drain out.
  task automatic wait_all_results();
    in_tvalid <= 1'b0;
    while (merge_sb.due_results.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // Both colour registers, back to back; only called with the block idle.
  task automatic write_colours(logic [63:0] col_a, logic [63:0] col_b);
    cfg_we    <= 1'b1;
    cfg_addr  <= REG_COLOR_A;
    cfg_wdata <= col_a;
    @(posedge clk);
    merge_sb.set_colour(REG_COLOR_A, col_a);
    cfg_addr  <= REG_COLOR_B;
    cfg_wdata <= col_b;
    @(posedge clk);
    merge_sb.set_colour(REG_COLOR_B, col_b);
    cfg_we    <= 1'b0;
  endtask

  // Mostly well-formed traffic: feed whichever stream the block wants next,
  // ascending in small steps so ties and duplicates are frequent. Now and then
  // the wanting stream jumps up to the other head (quick catch-up, exact ties)
  // or takes a big stride. About one in ten requests is a random push to
  // either stream: full-head drops and unsorted words.
  task automatic pick_merge_request(output smdc_cmd_t cmd, output logic [63:0] word);
    logic [1:0]  want;
    bit          to_b;
    bit          rival_full;
    logic [63:0] rival;
    logic [63:0] base;
    logic [63:0] step;
    want = merge_sb.wanted_streams();
    if (want == 2'b00 || $urandom_range(0, 9) == 0) begin
      cmd  = $urandom_range(0, 1) ? CMD_PUSH_B : CMD_PUSH_A;
      word = {$urandom, $urandom};
    end else begin
      to_b       = (want == 2'b10) || (want == 2'b11 && $urandom_range(0, 1) == 1);
      base       = to_b ? last_b : last_a;
      rival_full = to_b ? merge_sb.a_full : merge_sb.b_full;
      rival      = to_b ? merge_sb.a_word : merge_sb.b_word;
      if (rival_full && rival > base && $urandom_range(0, 2) == 0) base = rival;
      if ($urandom_range(0, 19) == 0) step = {$urandom, $urandom} >> $urandom_range(8, 63);
      else step = 64'($urandom_range(0, 3));
      word = base + step;
      // keep clear of the top: an all-ones head never compares below the other head
      if (word < base || word == '1) word = base;
      if (to_b) last_b = word;
      else last_a = word;
      cmd = to_b ? CMD_PUSH_B : CMD_PUSH_A;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result side: a stall pattern that is redrawn periodically (sometimes no
  // stalls at all), plus one long counted hold-off on request.
  // ---------------------------------------------------------------------------
  initial begin
    int          tick;
    logic [15:0] ready_pat;
    tick      = 0;
    ready_pat = '1;
    out_tready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
      end
      if (tick % 64 == 0) begin
        case ($urandom_range(0, 3))
          0:       ready_pat = '1;
          1:       ready_pat = 16'($urandom);
          2:       ready_pat = 16'h8421;
          default: ready_pat = 16'hfff0;
        endcase
      end
      out_tready <= ready_pat[tick % 16];
      tick++;
    end
  end

  // Every accepted result is checked against the oldest one due.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      merge_sb.check_result(out_tdata, out_tuser[0], out_tlast);
  end

  // Hang detection: count cycles with no handshake of any kind.
  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_tvalid && in_tready) || (out_tvalid && out_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= HANG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Main flow
  // ---------------------------------------------------------------------------
  initial begin
    smdc_cmd_t   cmd;
    logic [63:0] word;
    logic [63:0] col_a;
    logic [63:0] col_b;
    logic [63:0] tail;
    smdc_cmd_t   first_end;
    smdc_cmd_t   last_end;
    smdc_cmd_t   open_push;
    smdc_cmd_t   shut_push;

    rst_n        <= 1'b0;
    cfg_we       <= 1'b0;
    cfg_addr     <= REG_COLOR_A;
    cfg_wdata    <= '0;
    in_tvalid    <= 1'b0;
    in_tdata     <= '0;
    in_tuser     <= CMD_PUSH_A;
    burst_left   = 0;
    gap_max      = 3;
    hold_off_req = 1'b0;
    last_a       = '0;
    last_b       = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed opening, reset colours, both streams open. Walks through
    // empty steps, a drop on a full head, ties (B first), colour merging,
    // the top bit, alternating bit patterns and an out-of-order word.
    send_request(CMD_PUSH_A, 64'h0);                    // waits for B
    send_request(CMD_PUSH_A, 64'h7);                    // A full: dropped
    send_request(CMD_PUSH_B, 64'h0);                    // tie, B first
    send_request(CMD_PUSH_B, 64'h3);                    // A 0 joins pair
    send_request(CMD_PUSH_A, 64'h3);                    // tie, pair 0 out
    send_request(CMD_PUSH_B, 64'h3);                    // tie again
    send_request(CMD_PUSH_B, 64'h5555_5555_5555_5555);
    send_request(CMD_PUSH_A, 64'h8000_0000_0000_0000);
    send_request(CMD_PUSH_B, 64'haaaa_aaaa_aaaa_aaaa);
    send_request(CMD_PUSH_A, 64'hc000_0000_0000_0000);
    send_request(CMD_PUSH_B, 64'h1);                    // unsorted
    send_request(CMD_PUSH_A, 64'h0);                    // A full: dropped
    send_request(CMD_PUSH_B, 64'hc000_0000_0000_0000);  // tie at the top
    send_request(CMD_PUSH_B, 64'hc000_0000_0000_0001);

    // Random phases, each under its own colour pair. Streams stay open: once
    // both end the block is spent until the next reset.
    for (int phase = 0; phase < 6; phase++) begin
      wait_all_results();
      if (phase != 0) begin
        case (phase)
          1: begin col_a = '1; col_b = '0; end
          2: begin col_a = '0; col_b = '1; end
          3: begin col_a = {$urandom, $urandom}; col_b = {$urandom, $urandom}; end
          4: begin col_a = 64'h8000_0000_0000_0000; col_b = 64'h1; end
          default: begin col_a = {$urandom, $urandom}; col_b = col_a; end
        endcase
        write_colours(col_a, col_b);
      end
      last_a  = {$urandom, $urandom} >> $urandom_range(4, 63);
      last_b  = {$urandom, $urandom} >> $urandom_range(4, 63);
      gap_max = (phase == 2 || phase == 4) ? 0 : ((phase % 2 == 1) ? 12 : 4);
      // back-to-back requests against a stalled receiver: the block fills up
      if (phase == 2) hold_off_req = 1'b1;
      repeat (PHASE_REQS) begin
        pick_merge_request(cmd, word);
        send_request(cmd, word);
      end
    end

    // Closing: one stream ends (repeated end, drops on the closed side), the
    // other passes through alone, then the second end flushes the last pair
    // and further requests hit a drained block.
    wait_all_results();
    write_colours({$urandom, $urandom}, {$urandom, $urandom});
    gap_max   = 6;
    first_end = $urandom_range(0, 1) ? CMD_END_B : CMD_END_A;
    last_end  = (first_end == CMD_END_A) ? CMD_END_B : CMD_END_A;
    open_push = (first_end == CMD_END_A) ? CMD_PUSH_B : CMD_PUSH_A;
    shut_push = (first_end == CMD_END_A) ? CMD_PUSH_A : CMD_PUSH_B;
    tail      = {$urandom, $urandom} >> $urandom_range(8, 63);
    send_request(first_end, {$urandom, $urandom});
    send_request(first_end, '0);
    send_request(shut_push, {$urandom, $urandom});
    repeat (60) begin
      case ($urandom_range(0, 9))
        7: send_request(shut_push, {$urandom, $urandom});
        8: send_request(first_end, {$urandom, $urandom});
        9: send_request(open_push, {$urandom, $urandom});
        default: begin
          tail = tail + 64'($urandom_range(0, 2));
          send_request(open_push, tail);
        end
      endcase
    end
    send_request(open_push, '1);
    send_request(open_push, '1);
    send_request(last_end, '0);
    send_request(last_end, '1);
    send_request(first_end, '0);
    send_request(CMD_PUSH_A, '1);
    send_request(CMD_PUSH_B, '0);

    wait_all_results();
    repeat (8) @(posedge clk);
    if (merge_sb.mismatches == 0 && merge_sb.due_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/smdc_pkg.sv
rtl/core/smdc_core.sv
rtl/core/smdc_outq.sv
rtl/core/sorted_merge_dedup_color_top.sv
dv/testbench.sv
